@@ sv/hdlcrx_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the HDLC receive deframer.
package hdlcrx_pkg;

   localparam int BYTE_W       = 8;
   localparam int CRC_W        = 16;
   localparam int LEN_W        = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int MIN_FRAME    = 3;
   localparam int HELD_BYTES   = 2;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [BYTE_W-1:0] FLAG_RESET     = 8'h7E;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET   = 8'h7D;
   localparam logic [BYTE_W-1:0] MASK_RESET     = 8'h20;
   localparam logic [CRC_W-1:0]  POLY_RESET     = 16'h1021;
   localparam logic [CRC_W-1:0]  INIT_RESET     = 16'hFFFF;
   localparam logic              REFLECT_RESET  = 1'b0;
   localparam logic [CRC_W-1:0]  FINAL_RESET    = 16'h0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLAG_BYTE      = 3'd0,
      CSR_ESCAPE_BYTE    = 3'd1,
      CSR_ESCAPE_MASK    = 3'd2,
      CSR_CRC_POLYNOMIAL = 3'd3,
      CSR_CRC_INITIAL    = 3'd4,
      CSR_CRC_REFLECTED  = 3'd5,
      CSR_CRC_FINAL_XOR  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_WAIT = 2'd0,
      MODE_DATA = 2'd1,
      MODE_ESC  = 2'd2
   } rx_mode_type;

   typedef enum logic {
      EV_DATA = 1'b0,
      EV_FLAG = 1'b1
   } ev_kind_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2
   } result_kind_type;

   typedef struct packed {
      ev_kind_type        kind;
      logic [BYTE_W-1:0]  data;
   } event_type;

   typedef struct packed {
      result_kind_type    kind;
      logic [BYTE_W-1:0]  payload_byte;
      logic [LEN_W-1:0]   payload_length;
   } result_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  flag_byte;
      logic [BYTE_W-1:0]  escape_byte;
      logic [BYTE_W-1:0]  escape_mask;
   } framing_cfg_type;

   typedef struct packed {
      logic [CRC_W-1:0]   polynomial;
      logic [CRC_W-1:0]   initial_value;
      logic               reflected;
      logic [CRC_W-1:0]   final_xor;
   } crc_cfg_type;

   // One byte through a CRC-16; reflected mode uses the bit-reversed polynomial.
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [CRC_W-1:0] poly,
                                                   input logic refl);
      logic [CRC_W-1:0] c;
      logic [CRC_W-1:0] rpoly;
      for (int i = 0; i < CRC_W; i++) begin
         rpoly[i] = poly[CRC_W-1-i];
      end
      if (refl) begin
         c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
         for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
         end
      end else begin
         c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
         for (int i = 0; i < BYTE_W; i++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ poly) : (c << 1);
         end
      end
      return c;
   endfunction

endpackage

@@ sv/hdlc_rx_deframer_crc_check_top.sv @@
// Top level of the HDLC receive deframer with CRC-16 check.
//
//   channel  signals                                   direction  beat
//   req      push, full, req_rx_byte                   in         one raw line byte
//   rsp      empty, pop, rsp_result_kind,              out        payload byte or
//            rsp_payload_byte, rsp_payload_length                 frame status
//   csr      csr_write_en, csr_index, csr_wdata        in         one register write
//
// One byte a cycle sustained while full stays low; a result reaches rsp through the
// event queue and then the result queue, both registered, after its byte is taken.
// The back-end byte-wide CRC step sets the pace, one event per cycle unless res_full.
// Synchronous reset: queues empty, waiting for the opening flag, registers at defaults.
// full rises only when the event queue is full, i.e. when pop has been held low
// long enough for both queues to fill.
module hdlc_rx_deframer_crc_check_top #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   output logic                                      full,
   input  logic [7:0]                                req_rx_byte,
   output logic                                      empty,
   input  logic                                      pop,
   output logic [1:0]                                rsp_result_kind,
   output logic [7:0]                                rsp_payload_byte,
   output logic [7:0]                                rsp_payload_length,
   input  logic                                      csr_write_en,
   input  logic [hdlcrx_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [hdlcrx_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int EV_W  = $bits(hdlcrx_pkg::event_type);
   localparam int RES_W = $bits(hdlcrx_pkg::result_type);

   hdlcrx_pkg::framing_cfg_type framing_ff;
   hdlcrx_pkg::crc_cfg_type     crc_cfg_ff;

   logic                  accept;
   logic                  front_push;
   hdlcrx_pkg::event_type front_ev;
   logic [EV_W-1:0]       ev_bits;
   hdlcrx_pkg::event_type back_ev;
   logic                  ev_empty, ev_pop;
   logic                  res_full, res_push;
   hdlcrx_pkg::result_type back_res;
   logic [RES_W-1:0]      res_bits;
   hdlcrx_pkg::result_type out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         framing_ff.flag_byte     <= hdlcrx_pkg::FLAG_RESET;
         framing_ff.escape_byte   <= hdlcrx_pkg::ESCAPE_RESET;
         framing_ff.escape_mask   <= hdlcrx_pkg::MASK_RESET;
         crc_cfg_ff.polynomial    <= hdlcrx_pkg::POLY_RESET;
         crc_cfg_ff.initial_value <= hdlcrx_pkg::INIT_RESET;
         crc_cfg_ff.reflected     <= hdlcrx_pkg::REFLECT_RESET;
         crc_cfg_ff.final_xor     <= hdlcrx_pkg::FINAL_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            hdlcrx_pkg::CSR_FLAG_BYTE:      framing_ff.flag_byte     <= csr_wdata[7:0];
            hdlcrx_pkg::CSR_ESCAPE_BYTE:    framing_ff.escape_byte   <= csr_wdata[7:0];
            hdlcrx_pkg::CSR_ESCAPE_MASK:    framing_ff.escape_mask   <= csr_wdata[7:0];
            hdlcrx_pkg::CSR_CRC_POLYNOMIAL: crc_cfg_ff.polynomial    <= csr_wdata;
            hdlcrx_pkg::CSR_CRC_INITIAL:    crc_cfg_ff.initial_value <= csr_wdata;
            hdlcrx_pkg::CSR_CRC_REFLECTED:  crc_cfg_ff.reflected     <= csr_wdata[0];
            hdlcrx_pkg::CSR_CRC_FINAL_XOR:  crc_cfg_ff.final_xor     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign accept = push && !full;

   hdlcrx_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (framing_ff),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .ev_push (front_push),
      .ev      (front_ev)
   );

   hdlcrx_fifo #(
      .WIDTH (EV_W),
      .DEPTH (hdlcrx_pkg::QUEUE_DEPTH)
   ) u_ev_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_ev),
      .full      (full),
      .pop       (ev_pop),
      .pop_data  (ev_bits),
      .empty     (ev_empty)
   );

   assign back_ev = hdlcrx_pkg::event_type'(ev_bits);

   hdlcrx_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (crc_cfg_ff),
      .ev_valid (!ev_empty),
      .ev       (back_ev),
      .ev_pop   (ev_pop),
      .res_full (res_full),
      .res_push (res_push),
      .res      (back_res)
   );

   hdlcrx_fifo #(
      .WIDTH (RES_W),
      .DEPTH (hdlcrx_pkg::QUEUE_DEPTH)
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (back_res),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_bits),
      .empty     (empty)
   );

   assign out_res            = hdlcrx_pkg::result_type'(res_bits);
   assign rsp_result_kind    = out_res.kind;
   assign rsp_payload_byte   = out_res.payload_byte;
   assign rsp_payload_length = out_res.payload_length;

endmodule

@@ sv/hdlcrx_fifo.sv @@
// Small register-based FIFO used between the deframer stages and at the result side.
module hdlcrx_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/hdlcrx_front.sv @@
// Front end: flag and escape handling, turns raw bytes into data and flag events.
module hdlcrx_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hdlcrx_pkg::framing_cfg_type           cfg,
   input  logic                                  accept,
   input  logic [hdlcrx_pkg::BYTE_W-1:0]         rx_byte,
   output logic                                  ev_push,
   output hdlcrx_pkg::event_type                 ev
);

   hdlcrx_pkg::rx_mode_type mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hdlcrx_pkg::MODE_WAIT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      ev_push  = 1'b0;
      ev.kind  = hdlcrx_pkg::EV_DATA;
      ev.data  = rx_byte;
      if (accept) begin
         unique case (mode_ff)
            hdlcrx_pkg::MODE_WAIT: begin
               if (rx_byte == cfg.flag_byte) begin
                  ev_push = 1'b1;
                  ev.kind = hdlcrx_pkg::EV_FLAG;
                  mode_in = hdlcrx_pkg::MODE_DATA;
               end
            end
            hdlcrx_pkg::MODE_DATA: begin
               if (rx_byte == cfg.flag_byte) begin
                  ev_push = 1'b1;
                  ev.kind = hdlcrx_pkg::EV_FLAG;
               end else if (rx_byte == cfg.escape_byte) begin
                  mode_in = hdlcrx_pkg::MODE_ESC;
               end else begin
                  ev_push = 1'b1;
               end
            end
            hdlcrx_pkg::MODE_ESC: begin
               // a flag right after an escape is plain escaped data
               ev_push = 1'b1;
               ev.data = rx_byte ^ cfg.escape_mask;
               mode_in = hdlcrx_pkg::MODE_DATA;
            end
            default: begin
               mode_in = hdlcrx_pkg::MODE_WAIT;
            end
         endcase
      end
   end

endmodule

@@ sv/hdlcrx_back.sv @@
// Back end: two-byte hold line, running CRC, frame check and result building.
module hdlcrx_back #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hdlcrx_pkg::crc_cfg_type       cfg,
   input  logic                          ev_valid,
   input  hdlcrx_pkg::event_type         ev,
   output logic                          ev_pop,
   input  logic                          res_full,
   output logic                          res_push,
   output hdlcrx_pkg::result_type        res
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LW    = (CNT_W > 9) ? CNT_W : 9;

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [hdlcrx_pkg::BYTE_W-1:0]     held0_ff, held0_in;
   logic [hdlcrx_pkg::BYTE_W-1:0]     held1_ff, held1_in;
   logic [hdlcrx_pkg::CRC_W-1:0]      crc_ff, crc_in;
   logic                              fire;
   logic [LW-1:0]                     len_wide;
   logic [hdlcrx_pkg::LEN_W-1:0]      len;
   logic [hdlcrx_pkg::CRC_W-1:0]      crc_next;

   assign fire   = ev_valid && !res_full;
   assign ev_pop = fire;

   assign len_wide = LW'(count_ff) - LW'(hdlcrx_pkg::HELD_BYTES);
   assign len      = (len_wide > LW'(255)) ? 8'hFF : len_wide[hdlcrx_pkg::LEN_W-1:0];
   assign crc_next = hdlcrx_pkg::crc16_byte(crc_ff, held0_ff, cfg.polynomial, cfg.reflected);

   always_comb begin
      count_in           = count_ff;
      held0_in           = held0_ff;
      held1_in           = held1_ff;
      crc_in             = crc_ff;
      res_push           = 1'b0;
      res.kind           = hdlcrx_pkg::KIND_PAYLOAD;
      res.payload_byte   = '0;
      res.payload_length = '0;
      if (fire) begin
         case (ev.kind)
            hdlcrx_pkg::EV_FLAG: begin
               if (count_ff >= CNT_W'(hdlcrx_pkg::MIN_FRAME)) begin
                  res_push           = 1'b1;
                  res.kind           = ((crc_ff ^ cfg.final_xor) == {held1_ff, held0_ff})
                                       ? hdlcrx_pkg::KIND_ACCEPT : hdlcrx_pkg::KIND_REJECT;
                  res.payload_length = len;
               end
               count_in = '0;
               held0_in = '0;
               held1_in = '0;
               crc_in   = cfg.initial_value;
            end
            default: begin
               // frame full: drop further bytes silently
               if (count_ff != CNT_W'(MAX_FRAME_BYTES)) begin
                  if (count_ff >= CNT_W'(hdlcrx_pkg::HELD_BYTES)) begin
                     res_push         = 1'b1;
                     res.payload_byte = held0_ff;
                     crc_in           = crc_next;
                  end
                  held0_in = held1_ff;
                  held1_in = ev.data;
                  count_in = count_ff + 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held0_ff <= '0;
         held1_ff <= '0;
         crc_ff   <= hdlcrx_pkg::INIT_RESET;
      end else begin
         count_ff <= count_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         crc_ff   <= crc_in;
      end
   end

endmodule
